>>> design/bbcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbcm_pkg;

    typedef enum logic [3:0] {
        ALU_A    = 4'd0,
        ALU_ADD  = 4'd1,
        ALU_ADDC = 4'd2,
        ALU_SUB  = 4'd3,
        ALU_SUBC = 4'd4,
        ALU_AND  = 4'd5,
        ALU_NAND = 4'd6,
        ALU_OR   = 4'd7,
        ALU_NOR  = 4'd8,
        ALU_XOR  = 4'd9,
        ALU_NOT  = 4'd10,
        ALU_ASL  = 4'd11,
        ALU_ROL  = 4'd12,
        ALU_ASR  = 4'd13,
        ALU_ROR  = 4'd14,
        ALU_FLG  = 4'd15
    } t_alu_fn;

    typedef struct packed {
        logic n;
        logic z;
        logic v;
        logic c;
    } t_alu_flags;

    localparam int MUX_AMUX  = 0;
    localparam int MUX_CMUX  = 1;
    localparam int MUX_CSMUX = 2;
    localparam int MUX_MDR   = 3;
    localparam int MUX_ANDZ  = 4;

    localparam int CK_N   = 0;
    localparam int CK_Z   = 1;
    localparam int CK_V   = 2;
    localparam int CK_C   = 3;
    localparam int CK_S   = 4;
    localparam int CK_MAR = 5;
    localparam int CK_MDR = 6;
    localparam int CK_REG = 7;

    localparam int FL_N = 4;
    localparam int FL_Z = 3;
    localparam int FL_V = 2;
    localparam int FL_C = 1;
    localparam int FL_S = 0;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ADDR_CHG  = 3'd1;
    localparam logic [2:0] ST_DATA_CHG  = 3'd2;
    localparam logic [2:0] ST_TOO_SOON  = 3'd3;
    localparam logic [2:0] ST_HALTED    = 3'd4;

    localparam logic [1:0] CYC_IDLE  = 2'd0;
    localparam logic [1:0] CYC_ONE   = 2'd1;
    localparam logic [1:0] CYC_TWO   = 2'd2;
    localparam logic [1:0] CYC_THREE = 2'd3;

    function automatic logic [7:0] const_val(input logic [4:0] k);
        logic [7:0] v;
        begin
            unique case (k)
                5'd0:    v = 8'h00;
                5'd1:    v = 8'h01;
                5'd2:    v = 8'h02;
                5'd3:    v = 8'h03;
                5'd4:    v = 8'h04;
                5'd5:    v = 8'h08;
                5'd6:    v = 8'hF0;
                5'd7:    v = 8'hF6;
                5'd8:    v = 8'hFE;
                5'd9:    v = 8'hFF;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

>>> design/bbcm_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module bbcm_alu
    import bbcm_pkg::*;
(
    input  wire t_alu_fn    i_fn,
    input  wire logic [7:0] i_a,
    input  wire logic [7:0] i_b,
    input  wire logic       i_cin,
    output logic [7:0]      o_res,
    output t_alu_flags      o_flags
);

    logic [7:0] b_op;
    logic       c_in;
    logic [8:0] sum;
    logic [7:0] r;
    logic       v;
    logic       c;

    always_comb begin
        b_op = ((i_fn == ALU_SUB) || (i_fn == ALU_SUBC)) ? ~i_b : i_b;
        if (i_fn == ALU_ADD) begin
            c_in = 1'b0;
        end else if (i_fn == ALU_SUB) begin
            c_in = 1'b1;
        end else begin
            c_in = i_cin;
        end
        sum = {1'b0, i_a} + {1'b0, b_op} + {8'd0, c_in};
    end

    always_comb begin
        r = 8'd0;
        v = 1'b0;
        c = 1'b0;
        unique case (i_fn)
            ALU_A: r = i_a;
            ALU_ADD, ALU_ADDC, ALU_SUB, ALU_SUBC: begin
                r = sum[7:0];
                c = sum[8];
                v = (i_a[7] ^ sum[7]) & (b_op[7] ^ sum[7]);
            end
            ALU_AND:  r = i_a & i_b;
            ALU_NAND: r = ~(i_a & i_b);
            ALU_OR:   r = i_a | i_b;
            ALU_NOR:  r = ~(i_a | i_b);
            ALU_XOR:  r = i_a ^ i_b;
            ALU_NOT:  r = ~i_a;
            ALU_ASL: begin
                r = {i_a[6:0], 1'b0};
                c = i_a[7];
                v = i_a[7] ^ i_a[6];
            end
            ALU_ROL: begin
                r = {i_a[6:0], i_cin};
                c = i_a[7];
            end
            ALU_ASR: begin
                r = {i_a[7], i_a[7:1]};
                c = i_a[0];
            end
            ALU_ROR: begin
                r = {i_cin, i_a[7:1]};
                c = i_a[0];
            end
            ALU_FLG: begin
                r = 8'd0;
                v = i_a[1];
                c = i_a[0];
            end
        endcase
    end

    always_comb begin
        o_res = r;
        if (i_fn == ALU_FLG) begin
            o_flags.n = i_a[3];
            o_flags.z = i_a[2];
        end else begin
            o_flags.n = r[7];
            o_flags.z = (r == 8'd0);
        end
        o_flags.v = v;
        o_flags.c = c;
    end

endmodule

`default_nettype wire

>>> design/byte_bus_cpu_microstep.sv
// An item is registered at acceptance; its result goes into the output registers when the item advances.
// Throughput: one item per cycle unless the output stalls; ALU and all state updates run as an item advances.
// The register bank read is registered at acceptance, with forwarding from the item in execution.
// Reset clears valids, MAR, MDR, flags and status; bank entries read zero until written, constants fixed.
`timescale 1ns / 1ps
`default_nettype none

module byte_bus_cpu_microstep
    import bbcm_pkg::*;
#(
    parameter int FIRST_CONSTANT_REG = 22
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [4:0]  i_reg_a_sel,
    input  wire logic [4:0]  i_reg_b_sel,
    input  wire logic [4:0]  i_reg_c_sel,
    input  wire logic [3:0]  i_alu_function,
    input  wire logic [4:0]  i_mux_bits,
    input  wire logic [7:0]  i_clock_enables,
    input  wire logic        i_mem_read,
    input  wire logic        i_mem_write,
    input  wire logic [7:0]  i_mem_read_data,
    input  wire logic        i_last_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_c_bus,
    output logic [4:0]       o_flags,
    output logic [15:0]      o_mem_addr,
    output logic             o_mem_write_strobe,
    output logic [7:0]       o_mem_write_data,
    output logic             o_mem_read_taken,
    output logic [2:0]       o_status,
    output logic             o_pause
);

    localparam logic [4:0] FIRST_SEL = 5'(FIRST_CONSTANT_REG);

    logic [7:0]  r_bank [32];
    logic [31:0] r_bank_vld;

    logic        r_s1_valid;
    logic [4:0]  r_c_sel;
    logic [3:0]  r_fn;
    logic [4:0]  r_mux;
    logic [7:0]  r_ck;
    logic        r_mrd;
    logic        r_mwr;
    logic [7:0]  r_rdata;
    logic        r_last;
    logic [7:0]  r_a_mem;
    logic [7:0]  r_b_mem;
    logic [7:0]  r_a_alt;
    logic [7:0]  r_b_alt;
    logic        r_a_use_mem;
    logic        r_b_use_mem;

    logic [7:0]  r_mar_hi;
    logic [7:0]  r_mar_lo;
    logic [7:0]  r_mdr;
    logic [4:0]  r_fl;
    logic [1:0]  r_cyc;
    logic [2:0]  r_status;

    logic        r_out_valid;
    logic [7:0]  r_o_c_bus;
    logic [4:0]  r_o_flags;
    logic [15:0] r_o_addr;
    logic        r_o_strobe;
    logic [7:0]  r_o_wdata;
    logic        r_o_taken;

    logic        adv;
    logic        accept;
    logic        wr_en;
    logic [7:0]  a_bus;
    logic [7:0]  b_bus;
    logic [7:0]  alu_left;
    logic        cin;
    logic [7:0]  alu_res;
    t_alu_flags  alu_fl;
    logic [1:0]  n_cyc;
    logic        wstrobe;
    logic        mar_load;
    logic        mar_fault;
    logic [4:0]  n_fl;
    logic [7:0]  cout;
    logic        mdr_from_c;
    logic        mdr_late;
    logic        mdr_from_mem;
    logic        mdr_early;
    logic [2:0]  n_status;
    logic [7:0]  n_a_alt;
    logic [7:0]  n_b_alt;
    logic        n_a_use_mem;
    logic        n_b_use_mem;

    assign adv     = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || adv;
    assign accept  = i_valid && o_ready;

    assign a_bus    = r_a_use_mem ? r_a_mem : r_a_alt;
    assign b_bus    = r_b_use_mem ? r_b_mem : r_b_alt;
    assign alu_left = r_mux[MUX_AMUX] ? a_bus : r_mdr;
    assign cin      = r_mux[MUX_CSMUX] ? r_fl[FL_S] : r_fl[FL_C];

    bbcm_alu u_alu (
        .i_fn    (t_alu_fn'(r_fn)),
        .i_a     (alu_left),
        .i_b     (b_bus),
        .i_cin   (cin),
        .o_res   (alu_res),
        .o_flags (alu_fl)
    );

    always_comb begin
        if (r_mwr || r_mrd) begin
            n_cyc = (r_cyc == CYC_THREE) ? CYC_ONE : r_cyc + 2'd1;
        end else begin
            n_cyc = CYC_IDLE;
        end
        wstrobe   = r_mwr && (r_cyc == CYC_TWO);
        mar_fault = r_ck[CK_MAR] && (n_cyc != CYC_IDLE);
        mar_load  = r_ck[CK_MAR] && (n_cyc == CYC_IDLE);

        n_fl = r_fl;
        if (r_ck[CK_N]) n_fl[FL_N] = alu_fl.n;
        if (r_ck[CK_Z]) n_fl[FL_Z] = alu_fl.z && (!r_mux[MUX_ANDZ] || r_fl[FL_Z]);
        if (r_ck[CK_V]) n_fl[FL_V] = alu_fl.v;
        if (r_ck[CK_C]) n_fl[FL_C] = alu_fl.c;
        if (r_ck[CK_S]) n_fl[FL_S] = alu_fl.c;

        cout = r_mux[MUX_CMUX] ? alu_res
                               : {4'd0, n_fl[FL_N], n_fl[FL_Z], n_fl[FL_V], n_fl[FL_C]};

        mdr_from_c   = r_ck[CK_MDR] && r_mux[MUX_MDR];
        mdr_late     = mdr_from_c && (n_cyc == CYC_THREE);
        mdr_from_mem = r_ck[CK_MDR] && !r_mux[MUX_MDR] && (n_cyc == CYC_THREE);
        mdr_early    = r_ck[CK_MDR] && !r_mux[MUX_MDR] && (n_cyc != CYC_THREE);

        n_status = r_status;
        if (mar_fault)   n_status = ST_ADDR_CHG;
        if (mdr_late)    n_status = ST_DATA_CHG;
        if (mdr_early)   n_status = ST_TOO_SOON;
        if (r_last)      n_status = ST_HALTED;

        wr_en = adv && r_ck[CK_REG] && (r_c_sel < FIRST_SEL);
    end

    always_comb begin
        if (wr_en && (r_c_sel == i_reg_a_sel)) begin
            n_a_alt     = cout;
            n_a_use_mem = 1'b0;
        end else if (i_reg_a_sel >= FIRST_SEL) begin
            n_a_alt     = const_val(i_reg_a_sel - FIRST_SEL);
            n_a_use_mem = 1'b0;
        end else begin
            n_a_alt     = 8'd0;
            n_a_use_mem = r_bank_vld[i_reg_a_sel];
        end
        if (wr_en && (r_c_sel == i_reg_b_sel)) begin
            n_b_alt     = cout;
            n_b_use_mem = 1'b0;
        end else if (i_reg_b_sel >= FIRST_SEL) begin
            n_b_alt     = const_val(i_reg_b_sel - FIRST_SEL);
            n_b_use_mem = 1'b0;
        end else begin
            n_b_alt     = 8'd0;
            n_b_use_mem = r_bank_vld[i_reg_b_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bank[r_c_sel] <= cout;
        end
        if (accept) begin
            r_a_mem <= r_bank[i_reg_a_sel];
            r_b_mem <= r_bank[i_reg_b_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_vld <= '0;
        end else if (wr_en) begin
            r_bank_vld[r_c_sel] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c_sel     <= i_reg_c_sel;
            r_fn        <= i_alu_function;
            r_mux       <= i_mux_bits;
            r_ck        <= i_clock_enables;
            r_mrd       <= i_mem_read;
            r_mwr       <= i_mem_write;
            r_rdata     <= i_mem_read_data;
            r_last      <= i_last_word;
            r_a_alt     <= n_a_alt;
            r_b_alt     <= n_b_alt;
            r_a_use_mem <= n_a_use_mem;
            r_b_use_mem <= n_b_use_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mar_hi    <= 8'd0;
            r_mar_lo    <= 8'd0;
            r_mdr       <= 8'd0;
            r_fl        <= 5'd0;
            r_cyc       <= CYC_IDLE;
            r_status    <= ST_OK;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                r_cyc    <= n_cyc;
                r_fl     <= n_fl;
                r_status <= n_status;
                if (mar_load) begin
                    r_mar_hi <= a_bus;
                    r_mar_lo <= b_bus;
                end
                if (mdr_from_c) begin
                    r_mdr <= cout;
                end else if (mdr_from_mem) begin
                    r_mdr <= r_rdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_c_bus  <= cout;
            r_o_flags  <= n_fl;
            r_o_addr   <= {r_mar_hi, r_mar_lo};
            r_o_strobe <= wstrobe;
            r_o_wdata  <= wstrobe ? r_mdr : 8'd0;
            r_o_taken  <= mdr_from_mem;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_c_bus            = r_o_c_bus;
    assign o_flags            = r_o_flags;
    assign o_mem_addr         = r_o_addr;
    assign o_mem_write_strobe = r_o_strobe;
    assign o_mem_write_data   = r_o_wdata;
    assign o_mem_read_taken   = r_o_taken;
    assign o_status           = r_status;
    assign o_pause            = (r_status != ST_OK);

    a_status_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != ST_OK) |=> (r_status != ST_OK))
        else $error("sticky status returned to ok");

    a_s1_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> (r_s1_valid && $stable(r_fn) && $stable(r_c_sel)))
        else $error("waiting item lost or changed");

    a_wdata_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_strobe) |-> (r_o_wdata == 8'd0))
        else $error("write data not zero without strobe");

    a_const_never_written : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_c_sel < FIRST_SEL))
        else $error("write into constant entry");

endmodule

`default_nettype wire

>>> tb/microstep_checker.sv
`timescale 1ns / 1ps

module microstep_checker
    import bbcm_pkg::*;
#(
    parameter int FIRST_CONSTANT_REG = 22
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [4:0]  i_reg_a_sel,
    input  wire logic [4:0]  i_reg_b_sel,
    input  wire logic [4:0]  i_reg_c_sel,
    input  wire logic [3:0]  i_alu_function,
    input  wire logic [4:0]  i_mux_bits,
    input  wire logic [7:0]  i_clock_enables,
    input  wire logic        i_mem_read,
    input  wire logic        i_mem_write,
    input  wire logic [7:0]  i_mem_read_data,
    input  wire logic        i_last_word,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_c_bus,
    input  wire logic [4:0]  i_flags,
    input  wire logic [15:0] i_mem_addr,
    input  wire logic        i_mem_write_strobe,
    input  wire logic [7:0]  i_mem_write_data,
    input  wire logic        i_mem_read_taken,
    input  wire logic [2:0]  i_status,
    input  wire logic        i_pause,
    output int               o_mismatch_count,
    output int               o_pending
);

    typedef struct packed {
        logic [7:0]  c_bus;
        logic [4:0]  flags;
        logic [15:0] mem_addr;
        logic        wstrobe;
        logic [7:0]  wdata;
        logic        taken;
        logic [2:0]  status;
        logic        pause;
    } t_step_result;

    localparam logic [79:0] CONST_BYTES = {8'hFF, 8'hFE, 8'hF6, 8'hF0, 8'h08,
                                           8'h04, 8'h03, 8'h02, 8'h01, 8'h00};

    logic [7:0]   reg_bank [32];
    logic [7:0]   mar_hi;
    logic [7:0]   mar_lo;
    logic [7:0]   mdr_q;
    logic [4:0]   flags_q;
    logic [1:0]   mem_cycle_q;
    logic [2:0]   sticky_q;
    t_step_result expected_steps [$];
    int           mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    function automatic t_step_result execute_microstep();
        logic [7:0]   a_bus, b_bus, left, b_op, res, cout, mdr_start;
        logic [8:0]   sum;
        logic         cin, add_cin, is_add, wstrobe, taken;
        logic [4:0]   f;
        t_alu_flags   af;
        t_step_result r;
        a_bus = reg_bank[i_reg_a_sel];
        b_bus = reg_bank[i_reg_b_sel];
        mdr_start = mdr_q;
        cin = i_mux_bits[MUX_CSMUX] ? flags_q[FL_S] : flags_q[FL_C];
        left = i_mux_bits[MUX_AMUX] ? a_bus : mdr_start;
        af = '0;
        res = '0;
        is_add = 1'b0;
        b_op = b_bus;
        add_cin = cin;
        wstrobe = 1'b0;
        taken = 1'b0;

        case (t_alu_fn'(i_alu_function))
            ALU_A:    res = left;
            ALU_ADD:  begin
                is_add = 1'b1;
                add_cin = 1'b0;
            end
            ALU_ADDC: is_add = 1'b1;
            ALU_SUB:  begin
                is_add = 1'b1;
                b_op = ~b_bus;
                add_cin = 1'b1;
            end
            ALU_SUBC: begin
                is_add = 1'b1;
                b_op = ~b_bus;
            end
            ALU_AND:  res = left & b_bus;
            ALU_NAND: res = ~(left & b_bus);
            ALU_OR:   res = left | b_bus;
            ALU_NOR:  res = ~(left | b_bus);
            ALU_XOR:  res = left ^ b_bus;
            ALU_NOT:  res = ~left;
            ALU_ASL:  begin
                res = {left[6:0], 1'b0};
                af.c = left[7];
                af.v = left[7] ^ left[6];
            end
            ALU_ROL:  begin
                res = {left[6:0], cin};
                af.c = left[7];
            end
            ALU_ASR:  begin
                res = {left[7], left[7:1]};
                af.c = left[0];
            end
            ALU_ROR:  begin
                res = {cin, left[7:1]};
                af.c = left[0];
            end
            default:  res = '0;
        endcase
        if (is_add) begin
            sum = {1'b0, left} + {1'b0, b_op} + {8'd0, add_cin};
            res = sum[7:0];
            af.c = sum[8];
            af.v = (left[7] ^ res[7]) & (b_op[7] ^ res[7]);
        end
        if (t_alu_fn'(i_alu_function) == ALU_FLG) begin
            af = left[3:0];
        end else begin
            af.n = res[7];
            af.z = (res == 8'd0);
        end

        r.mem_addr = {mar_hi, mar_lo};
        if (i_mem_write || i_mem_read) begin
            wstrobe = i_mem_write && (mem_cycle_q == CYC_TWO);
            mem_cycle_q = (mem_cycle_q == CYC_THREE) ? CYC_ONE : mem_cycle_q + 2'd1;
        end else begin
            mem_cycle_q = CYC_IDLE;
        end

        if (i_clock_enables[CK_MAR]) begin
            if (mem_cycle_q != CYC_IDLE) begin
                sticky_q = ST_ADDR_CHG;
            end else begin
                mar_hi = a_bus;
                mar_lo = b_bus;
            end
        end

        f = flags_q;
        if (i_clock_enables[CK_N]) f[FL_N] = af.n;
        if (i_clock_enables[CK_Z]) f[FL_Z] = af.z && (!i_mux_bits[MUX_ANDZ] || flags_q[FL_Z]);
        if (i_clock_enables[CK_V]) f[FL_V] = af.v;
        if (i_clock_enables[CK_C]) f[FL_C] = af.c;
        if (i_clock_enables[CK_S]) f[FL_S] = af.c;
        flags_q = f;

        cout = i_mux_bits[MUX_CMUX] ? res : {4'd0, f[FL_N], f[FL_Z], f[FL_V], f[FL_C]};

        if (i_clock_enables[CK_MDR]) begin
            if (i_mux_bits[MUX_MDR]) begin
                if (mem_cycle_q == CYC_THREE) sticky_q = ST_DATA_CHG;
                mdr_q = cout;
            end else if (mem_cycle_q == CYC_THREE) begin
                mdr_q = i_mem_read_data;
                taken = 1'b1;
            end else begin
                sticky_q = ST_TOO_SOON;
            end
        end
        if (i_clock_enables[CK_REG] && i_reg_c_sel < FIRST_CONSTANT_REG) begin
            reg_bank[i_reg_c_sel] = cout;
        end
        if (i_last_word) sticky_q = ST_HALTED;

        r.c_bus = cout;
        r.flags = flags_q;
        r.wstrobe = wstrobe;
        r.wdata = wstrobe ? mdr_start : 8'd0;
        r.taken = taken;
        r.status = sticky_q;
        r.pause = (sticky_q != ST_OK);
        return r;
    endfunction

    function automatic string fmt_step(input t_step_result r);
        return $sformatf("c_bus=%h flags=%b addr=%h wstb=%b wdata=%h taken=%b status=%0d pause=%b",
                         r.c_bus, r.flags, r.mem_addr, r.wstrobe, r.wdata, r.taken,
                         r.status, r.pause);
    endfunction

    always @(posedge i_clk) begin
        t_step_result got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                if (i >= FIRST_CONSTANT_REG && i - FIRST_CONSTANT_REG < 10) begin
                    reg_bank[i] = CONST_BYTES[8 * (i - FIRST_CONSTANT_REG) +: 8];
                end else begin
                    reg_bank[i] = 8'd0;
                end
            end
            mar_hi = '0;
            mar_lo = '0;
            mdr_q = '0;
            flags_q = '0;
            mem_cycle_q = CYC_IDLE;
            sticky_q = ST_OK;
            expected_steps.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_steps.push_back(execute_microstep());
            end
            if (i_out_valid && i_out_ready) begin
                got.c_bus = i_c_bus;
                got.flags = i_flags;
                got.mem_addr = i_mem_addr;
                got.wstrobe = i_mem_write_strobe;
                got.wdata = i_mem_write_data;
                got.taken = i_mem_read_taken;
                got.status = i_status;
                got.pause = i_pause;
                if (expected_steps.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result with no item pending: %s", $realtime,
                                 fmt_step(got));
                    end
                end else begin
                    want = expected_steps.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: step result mismatch", $realtime);
                            $display("    expected %s", fmt_step(want));
                            $display("    actual   %s", fmt_step(got));
                        end
                    end
                end
            end
        end
        o_pending <= expected_steps.size();
    end

endmodule

>>> tb/tb_byte_bus_cpu_microstep.sv
`timescale 1ns / 1ps

module tb_byte_bus_cpu_microstep
    import bbcm_pkg::*;
();

    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic [4:0] c_sel;
        logic [3:0] fn;
        logic [4:0] mux;
        logic [7:0] ck;
        logic       rd;
        logic       wr;
        logic [7:0] rdata;
        logic       last;
    } t_micro_item;

    localparam logic [4:0] MX_A  = 5'(1 << MUX_AMUX);
    localparam logic [4:0] MX_C  = 5'(1 << MUX_CMUX);
    localparam logic [4:0] MX_CS = 5'(1 << MUX_CSMUX);
    localparam logic [4:0] MX_M  = 5'(1 << MUX_MDR);
    localparam logic [4:0] MX_Z  = 5'(1 << MUX_ANDZ);
    localparam logic [7:0] CE_FLAGS = 8'((1 << CK_N) | (1 << CK_Z) | (1 << CK_V) |
                                         (1 << CK_C) | (1 << CK_S));
    localparam logic [7:0] CE_MAR = 8'(1 << CK_MAR);
    localparam logic [7:0] CE_MDR = 8'(1 << CK_MDR);
    localparam logic [7:0] CE_REG = 8'(1 << CK_REG);
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int END_SETTLE = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [4:0]  i_reg_a_sel;
    logic [4:0]  i_reg_b_sel;
    logic [4:0]  i_reg_c_sel;
    logic [3:0]  i_alu_function;
    logic [4:0]  i_mux_bits;
    logic [7:0]  i_clock_enables;
    logic        i_mem_read;
    logic        i_mem_write;
    logic [7:0]  i_mem_read_data;
    logic        i_last_word;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_c_bus;
    logic [4:0]  o_flags;
    logic [15:0] o_mem_addr;
    logic        o_mem_write_strobe;
    logic [7:0]  o_mem_write_data;
    logic        o_mem_read_taken;
    logic [2:0]  o_status;
    logic        o_pause;

    int mismatch_count;
    int pending_results;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    byte_bus_cpu_microstep u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_reg_a_sel        (i_reg_a_sel),
        .i_reg_b_sel        (i_reg_b_sel),
        .i_reg_c_sel        (i_reg_c_sel),
        .i_alu_function     (i_alu_function),
        .i_mux_bits         (i_mux_bits),
        .i_clock_enables    (i_clock_enables),
        .i_mem_read         (i_mem_read),
        .i_mem_write        (i_mem_write),
        .i_mem_read_data    (i_mem_read_data),
        .i_last_word        (i_last_word),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_c_bus            (o_c_bus),
        .o_flags            (o_flags),
        .o_mem_addr         (o_mem_addr),
        .o_mem_write_strobe (o_mem_write_strobe),
        .o_mem_write_data   (o_mem_write_data),
        .o_mem_read_taken   (o_mem_read_taken),
        .o_status           (o_status),
        .o_pause            (o_pause)
    );

    microstep_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_reg_a_sel        (i_reg_a_sel),
        .i_reg_b_sel        (i_reg_b_sel),
        .i_reg_c_sel        (i_reg_c_sel),
        .i_alu_function     (i_alu_function),
        .i_mux_bits         (i_mux_bits),
        .i_clock_enables    (i_clock_enables),
        .i_mem_read         (i_mem_read),
        .i_mem_write        (i_mem_write),
        .i_mem_read_data    (i_mem_read_data),
        .i_last_word        (i_last_word),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_c_bus            (o_c_bus),
        .i_flags            (o_flags),
        .i_mem_addr         (o_mem_addr),
        .i_mem_write_strobe (o_mem_write_strobe),
        .i_mem_write_data   (o_mem_write_data),
        .i_mem_read_taken   (o_mem_read_taken),
        .i_status           (o_status),
        .i_pause            (o_pause),
        .o_mismatch_count   (mismatch_count),
        .o_pending          (pending_results)
    );

    function automatic t_micro_item mk(input int a, b, c, input t_alu_fn fn,
                                       input logic [4:0] mux, input logic [7:0] ck,
                                       input int rd, wr, rdata, last);
        t_micro_item it;
        it.a_sel = 5'(a);
        it.b_sel = 5'(b);
        it.c_sel = 5'(c);
        it.fn = fn;
        it.mux = mux;
        it.ck = ck;
        it.rd = 1'(rd);
        it.wr = 1'(wr);
        it.rdata = 8'(rdata);
        it.last = 1'(last);
        return it;
    endfunction

    function automatic t_micro_item random_microstep();
        t_micro_item it;
        it.a_sel = 5'($urandom_range(31));
        it.b_sel = 5'($urandom_range(31));
        it.c_sel = 5'($urandom_range(31));
        it.fn = 4'($urandom_range(15));
        it.mux = 5'($urandom_range(31));
        it.ck = 8'($urandom_range(255));
        it.rd = 1'($urandom_range(1));
        it.wr = 1'($urandom_range(1));
        it.rdata = 8'($urandom_range(255));
        it.last = ($urandom_range(63) == 0);
        return it;
    endfunction

    task automatic offer_microstep(input t_micro_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_reg_a_sel <= it.a_sel;
        i_reg_b_sel <= it.b_sel;
        i_reg_c_sel <= it.c_sel;
        i_alu_function <= it.fn;
        i_mux_bits <= it.mux;
        i_clock_enables <= it.ck;
        i_mem_read <= it.rd;
        i_mem_write <= it.wr;
        i_mem_read_data <= it.rdata;
        i_last_word <= it.last;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Most items come as memory read or write sequences: a MAR load with the
    // bus idle followed by three memory cycles. In one sequence in eight, one item
    // is left fully random to break the protocol.
    task automatic run_random_items(input int count);
        int target, kind, brk;
        t_micro_item it;
        target = items_sent + count;
        while (items_sent < target) begin
            kind = $urandom_range(9);
            brk = ($urandom_range(7) == 0) ? $urandom_range(3) : 4;
            if (kind < 4) begin
                offer_microstep(random_microstep());
            end else begin
                for (int k = 0; k < 4; k++) begin
                    it = random_microstep();
                    if (k != brk) begin
                        it.last = 1'b0;
                        it.ck[CK_MAR] = (k == 0);
                        if (k == 0) begin
                            it.rd = 1'b0;
                            it.wr = 1'b0;
                            it.ck[CK_MDR] = (kind >= 7);
                            it.mux[MUX_MDR] = 1'b1;
                        end else if (kind < 7) begin
                            it.rd = 1'b1;
                            it.wr = 1'b0;
                            it.ck[CK_MDR] = (k == 3);
                            it.mux[MUX_MDR] = 1'b0;
                        end else begin
                            it.wr = 1'b1;
                            it.ck[CK_MDR] = 1'b0;
                        end
                    end
                    offer_microstep(it);
                end
            end
        end
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("byte_bus_cpu_microstep test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_reg_a_sel <= '0;
        i_reg_b_sel <= '0;
        i_reg_c_sel <= '0;
        i_alu_function <= '0;
        i_mux_bits <= '0;
        i_clock_enables <= '0;
        i_mem_read <= 1'b0;
        i_mem_write <= 1'b0;
        i_mem_read_data <= '0;
        i_last_word <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer_microstep(mk(31, 31, 0, ALU_A, MX_A | MX_C, CE_FLAGS | CE_REG, 0, 0, 0, 0));
        offer_microstep(mk(0, 0, 1, ALU_ADD, MX_A | MX_C, CE_FLAGS | CE_REG, 0, 0, 0, 0));
        offer_microstep(mk(31, 22, 2, ALU_ADDC, MX_A | MX_C, CE_FLAGS | CE_REG, 0, 0, 0, 0));
        offer_microstep(mk(23, 31, 3, ALU_SUB, MX_A | MX_C, CE_FLAGS | CE_REG, 0, 0, 0, 0));
        offer_microstep(mk(28, 27, 4, ALU_SUBC, MX_A | MX_C | MX_CS, CE_FLAGS | CE_REG,
                           0, 0, 0, 0));
        offer_microstep(mk(31, 28, 5, ALU_AND, MX_A | MX_C, CE_FLAGS | CE_REG, 0, 0, 0, 0));
        offer_microstep(mk(29, 31, 6, ALU_NAND, MX_A | MX_C | MX_Z, CE_FLAGS | CE_REG,
                           0, 0, 0, 0));
        offer_microstep(mk(22, 22, 7, ALU_OR, MX_A | MX_C | MX_Z, CE_FLAGS | CE_REG,
                           0, 0, 0, 0));
        offer_microstep(mk(22, 22, 8, ALU_NOR, 5'd0, CE_FLAGS | CE_REG, 0, 0, 0, 0));
        offer_microstep(mk(29, 30, 9, ALU_XOR, MX_A | MX_C, CE_FLAGS | CE_REG, 0, 0, 0, 0));
        offer_microstep(mk(0, 0, 10, ALU_NOT, MX_C, CE_FLAGS | CE_REG, 0, 0, 0, 0));
        // Load MAR and MDR with the bus idle; the bank write hits a constant entry.
        offer_microstep(mk(31, 30, 31, ALU_A, MX_A | MX_C | MX_M, CE_MAR | CE_MDR | CE_REG,
                           0, 0, 0, 0));
        offer_microstep(mk(28, 0, 11, ALU_ASL, MX_A | MX_C, CE_FLAGS | CE_REG, 0, 1, 0, 0));
        offer_microstep(mk(29, 0, 12, ALU_ROL, MX_A | MX_C, CE_FLAGS | CE_REG, 0, 1, 0, 0));
        offer_microstep(mk(31, 0, 13, ALU_ASR, MX_A | MX_C, CE_FLAGS | CE_REG, 0, 1, 0, 0));
        offer_microstep(mk(25, 0, 14, ALU_ROR, MX_A | MX_C | MX_CS, CE_FLAGS | CE_REG,
                           1, 0, 0, 0));
        offer_microstep(mk(27, 0, 15, ALU_FLG, MX_A | MX_C, CE_FLAGS | CE_REG, 1, 0, 0, 0));
        offer_microstep(mk(0, 1, 16, ALU_ADD, MX_A | MX_C, CE_MDR | CE_FLAGS | CE_REG,
                           1, 0, 8'hA5, 0));
        // MAR load while a read is under way, then an MDR load from the C bus
        // on the third read cycle, then a memory load with the bus idle.
        offer_microstep(mk(30, 29, 17, ALU_XOR, MX_A | MX_C, CE_MAR | CE_FLAGS, 1, 0, 0, 0));
        offer_microstep(mk(0, 0, 0, ALU_A, 5'd0, 8'd0, 1, 0, 0, 0));
        offer_microstep(mk(1, 2, 18, ALU_SUB, MX_A | MX_C | MX_M,
                           CE_MDR | CE_FLAGS | CE_REG, 1, 0, 0, 0));
        offer_microstep(mk(0, 0, 0, ALU_A, MX_A, CE_MDR, 0, 0, 8'h5A, 0));
        offer_microstep(mk(31, 31, 31, ALU_FLG, 5'h1F, 8'hFF, 1, 1, 8'hFF, 1));
        offer_microstep(mk(3, 4, 19, ALU_ADDC, MX_A | MX_C, CE_FLAGS | CE_REG, 0, 0, 0, 0));
        wait_results_drained();

        run_random_items(100);
        hold_req = 1'b1;
        run_random_items(275);
        wait_results_drained();

        send_idle_pct = 88;
        run_random_items(375);
        wait_results_drained();

        send_idle_pct = 0;
        recv_stall_pct = 88;
        run_random_items(375);
        wait_results_drained();

        send_idle_pct = 17;
        recv_stall_pct = 17;
        run_random_items(375);
        wait_results_drained();

        recv_stall_pct = 0;
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("byte_bus_cpu_microstep test passed");
        end else begin
            $display("byte_bus_cpu_microstep test failed");
        end
        $finish;
    end

endmodule
